// ===== hw/rtl/sphere_sphere_contact_macros.svh =====
// Assertion helpers for the sphere contact block.
// Both expect aclk and aresetn in the scope of use.
`ifndef SPHERE_SPHERE_CONTACT_MACROS_SVH
`define SPHERE_SPHERE_CONTACT_MACROS_SVH
`ifndef SYNTHESIS
`define SSC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ssc check failed");
`define SSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ssc check failed");
`else
`define SSC_ASSERT_IMPL(lbl, ante, cons)
`define SSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/ssc_pkg.sv =====
package ssc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int ID_WIDTH    = 16;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;
    localparam int NORM_WIDTH  = 16;
    localparam int NORM_FRAC   = 14;
    localparam int NORM_QW     = NORM_FRAC + 1;
    localparam int PEN_WIDTH   = 32;
    localparam int NUM_WIDTH   = COORD_WIDTH + NORM_FRAC + 2;
    localparam int AXES        = 3;

    localparam logic [NORM_QW-1:0] NORM_ONE = {1'b1, {NORM_FRAC{1'b0}}};

    // one candidate pair
    typedef struct packed {
        logic        [ID_WIDTH-1:0]    first_id;
        logic signed [COORD_WIDTH-1:0] first_center_x;
        logic signed [COORD_WIDTH-1:0] first_center_y;
        logic signed [COORD_WIDTH-1:0] first_center_z;
        logic        [RAD_WIDTH-1:0]   first_radius;
        logic        [ID_WIDTH-1:0]    second_id;
        logic signed [COORD_WIDTH-1:0] second_center_x;
        logic signed [COORD_WIDTH-1:0] second_center_y;
        logic signed [COORD_WIDTH-1:0] second_center_z;
        logic        [RAD_WIDTH-1:0]   second_radius;
    } ssc_req_t;

    // one contact
    typedef struct packed {
        logic        [ID_WIDTH-1:0]    body_a;
        logic        [ID_WIDTH-1:0]    body_b;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic signed [NORM_WIDTH-1:0]  normal_x;
        logic signed [NORM_WIDTH-1:0]  normal_y;
        logic signed [NORM_WIDTH-1:0]  normal_z;
        logic        [PEN_WIDTH-1:0]   penetration_depth;
    } ssc_res_t;

endpackage

// ===== hw/rtl/ssc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, rounded down.
module ssc_sqrt import ssc_pkg::*; #(
    parameter int RootW = COORD_WIDTH,
    parameter int SideW = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [2*RootW-1:0]   in_val,
    input  logic [SideW-1:0]     in_side,
    output logic                 out_valid,
    output logic [RootW-1:0]     out_root,
    output logic [SideW-1:0]     out_side
);

    localparam int VW = 2 * RootW;

    logic             valid_reg [RootW];
    logic [VW-1:0]    rem_reg   [RootW];
    logic [RootW-1:0] root_reg  [RootW];
    logic [SideW-1:0] side_reg  [RootW];

    for (genvar s = 0; s < RootW; s++) begin : g_stage
        localparam int B = RootW - 1 - s;
        logic             v_in;
        logic [VW-1:0]    rem_in;
        logic [RootW-1:0] root_in;
        logic [SideW-1:0] side_in;
        logic [VW:0]      trial;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_val;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
        assign trial = ({{(RootW+1){1'b0}}, root_in} << (B + 1))
                     + ((VW+1)'(1) << (2 * B));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[s] <= side_in;
                if ({1'b0, rem_in} >= trial) begin
                    rem_reg[s]  <= VW'({1'b0, rem_in} - trial);
                    root_reg[s] <= root_in | (RootW'(1) << B);
                end else begin
                    rem_reg[s]  <= rem_in;
                    root_reg[s] <= root_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[RootW-1];
    assign out_root  = root_reg[RootW-1];
    assign out_side  = side_reg[RootW-1];

endmodule

// ===== hw/rtl/ssc_div.sv =====
// Pipelined restoring divider, several lanes sharing one divisor,
// one quotient bit per stage.
module ssc_div import ssc_pkg::*; #(
    parameter int Lanes = AXES,
    parameter int NumW  = NUM_WIDTH,
    parameter int DivW  = COORD_WIDTH,
    parameter int QuoW  = NORM_QW,
    parameter int SideW = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [Lanes-1:0][NumW-1:0] in_num,
    input  logic [DivW-1:0]            in_div,
    input  logic [SideW-1:0]           in_side,
    output logic                       out_valid,
    output logic [Lanes-1:0][QuoW-1:0] out_quo,
    output logic [SideW-1:0]           out_side
);

    logic                       valid_reg [QuoW];
    logic [Lanes-1:0][NumW-1:0] rem_reg   [QuoW];
    logic [Lanes-1:0][QuoW-1:0] quo_reg   [QuoW];
    logic [DivW-1:0]            div_reg   [QuoW];
    logic [SideW-1:0]           side_reg  [QuoW];

    for (genvar s = 0; s < QuoW; s++) begin : g_stage
        localparam int K = QuoW - 1 - s;
        logic                       v_in;
        logic [Lanes-1:0][NumW-1:0] rem_in;
        logic [Lanes-1:0][QuoW-1:0] quo_in;
        logic [DivW-1:0]            div_in;
        logic [SideW-1:0]           side_in;
        logic [NumW-1:0]            trial;
        logic [Lanes-1:0][NumW-1:0] rem_next;
        logic [Lanes-1:0][QuoW-1:0] quo_next;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_num;
            assign quo_in  = '0;
            assign div_in  = in_div;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign quo_in  = quo_reg[s-1];
            assign div_in  = div_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign trial = NumW'(div_in) << K;

        // subtract the shifted divisor where it fits
        always_comb begin
            for (int l = 0; l < Lanes; l++) begin
                if (rem_in[l] >= trial) begin
                    rem_next[l] = rem_in[l] - trial;
                    quo_next[l] = quo_in[l] | (QuoW'(1) << K);
                end else begin
                    rem_next[l] = rem_in[l];
                    quo_next[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
                div_reg[s]  <= div_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QuoW-1];
    assign out_quo   = quo_reg[QuoW-1];
    assign out_side  = side_reg[QuoW-1];

endmodule

// ===== hw/rtl/sphere_sphere_contact.sv =====
// Sphere-sphere contact pipeline.
// Throughput: one pair per cycle while the output is not stalled; the square root
// (one bit per stage) and the normal divider (one bit per stage) set the depth, not
// the rate.
// Pairs that do not overlap leave no contact. Reset clears all valid bits only.
`include "sphere_sphere_contact_macros.svh"
module sphere_sphere_contact import ssc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ssc_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ssc_res_t m_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;
    localparam int SQW = 2 * DW;
    localparam int R2W = 2 * CW;
    localparam int AW  = CW + 2;
    localparam int PRW = NORM_QW + CW + 1;
    localparam int OFW = PRW + 1 - (NORM_FRAC + 1);
    localparam int PW  = CW + 3;
    localparam int PXW = (CW > PEN_WIDTH) ? CW : PEN_WIDTH;

    typedef struct packed {
        logic [ID_WIDTH-1:0]           ida;
        logic [ID_WIDTH-1:0]           idb;
        logic [AXES-1:0][CW-1:0]       a;
        logic [AXES-1:0][DW-1:0]       dmag;
        logic [AXES-1:0]               dneg;
        logic [RAD_WIDTH-1:0]          ra;
        logic [CW-1:0]                 rsum;
    } geo_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0]           ida;
        logic [ID_WIDTH-1:0]           idb;
        logic [AXES-1:0][CW-1:0]       a;
        logic [AXES-1:0]               dneg;
        logic [AW-1:0]                 arm;
        logic [CW-1:0]                 pen;
        logic                          zero;
    } prep_t;

    logic     m_valid_reg;
    ssc_res_t m_data_reg;

    logic adv;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // stage 1: deltas and radius sum
    logic [AXES-1:0][CW-1:0] in_a, in_b;
    logic [DW-1:0]           d_raw [AXES];
    geo_t                    geo_in;

    assign in_a = {s_data.first_center_z, s_data.first_center_y, s_data.first_center_x};
    assign in_b = {s_data.second_center_z, s_data.second_center_y, s_data.second_center_x};

    always_comb begin
        geo_in.ida  = s_data.first_id;
        geo_in.idb  = s_data.second_id;
        geo_in.a    = in_a;
        geo_in.ra   = s_data.first_radius;
        geo_in.rsum = {1'b0, s_data.first_radius} + {1'b0, s_data.second_radius};
        for (int i = 0; i < AXES; i++) begin
            d_raw[i]       = {in_b[i][CW-1], in_b[i]} - {in_a[i][CW-1], in_a[i]};
            geo_in.dneg[i] = d_raw[i][DW-1];
            geo_in.dmag[i] = d_raw[i][DW-1] ? (~d_raw[i] + DW'(1)) : d_raw[i];
        end
    end

    logic st1_valid_reg;
    geo_t st1_geo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (adv) begin
            st1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_geo_reg <= geo_in;
        end
    end

    // stage 2: squares
    logic           st2_valid_reg;
    geo_t           st2_geo_reg;
    logic [SQW-1:0] st2_sq_reg [AXES];
    logic [R2W-1:0] st2_rsum2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (adv) begin
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st2_geo_reg   <= st1_geo_reg;
            st2_rsum2_reg <= R2W'(st1_geo_reg.rsum) * R2W'(st1_geo_reg.rsum);
            for (int i = 0; i < AXES; i++) begin
                st2_sq_reg[i] <= SQW'(st1_geo_reg.dmag[i]) * SQW'(st1_geo_reg.dmag[i]);
            end
        end
    end

    // stage 3: squared distance and overlap test; misses drop out here
    logic [SQW-1:0] dist2;
    logic           hit;
    logic           st3_valid_reg;
    geo_t           st3_geo_reg;
    logic [R2W-1:0] st3_dist2_reg;

    assign dist2 = st2_sq_reg[0] + st2_sq_reg[1] + st2_sq_reg[2];
    assign hit   = dist2 < SQW'(st2_rsum2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_valid_reg <= 1'b0;
        end else if (adv) begin
            st3_valid_reg <= st2_valid_reg && hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st3_geo_reg   <= st2_geo_reg;
            st3_dist2_reg <= dist2[R2W-1:0];
        end
    end

    // distance
    logic                sq_valid;
    logic [CW-1:0]       sq_root;
    logic [$bits(geo_t)-1:0] sq_side;
    geo_t                sq_geo;

    ssc_sqrt #(
        .RootW (CW),
        .SideW ($bits(geo_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (st3_valid_reg),
        .in_val    (st3_dist2_reg),
        .in_side   (st3_geo_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign sq_geo = geo_t'(sq_side);

    // stage 4: divider operands, penetration and lever arm
    logic [AXES-1:0][NUM_WIDTH-1:0] num;
    prep_t                          prep_in;

    always_comb begin
        prep_in.ida  = sq_geo.ida;
        prep_in.idb  = sq_geo.idb;
        prep_in.a    = sq_geo.a;
        prep_in.dneg = sq_geo.dneg;
        prep_in.pen  = sq_geo.rsum - sq_root;
        prep_in.arm  = {2'b00, sq_geo.ra, 1'b0} - {2'b00, prep_in.pen};
        prep_in.zero = (sq_root == '0);
        for (int i = 0; i < AXES; i++) begin
            num[i] = NUM_WIDTH'({sq_geo.dmag[i], {NORM_FRAC{1'b0}}})
                   + NUM_WIDTH'(sq_root >> 1);
        end
    end

    logic                           st4_valid_reg;
    logic [AXES-1:0][NUM_WIDTH-1:0] st4_num_reg;
    logic [CW-1:0]                  st4_div_reg;
    prep_t                          st4_prep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st4_valid_reg <= 1'b0;
        end else if (adv) begin
            st4_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st4_num_reg  <= num;
            st4_div_reg  <= sq_root;
            st4_prep_reg <= prep_in;
        end
    end

    // normal components
    logic                         dv_valid;
    logic [AXES-1:0][NORM_QW-1:0] dv_quo;
    logic [$bits(prep_t)-1:0]     dv_side;
    prep_t                        dv_prep;

    ssc_div #(
        .Lanes (AXES),
        .NumW  (NUM_WIDTH),
        .DivW  (CW),
        .QuoW  (NORM_QW),
        .SideW ($bits(prep_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (st4_valid_reg),
        .in_num    (st4_num_reg),
        .in_div    (st4_div_reg),
        .in_side   (st4_prep_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    assign dv_prep = prep_t'(dv_side);

    // stage 5: signed normal and lever product
    logic [NORM_QW-1:0]    nmag  [AXES];
    logic                  nneg  [AXES];
    logic [NORM_WIDTH-1:0] nval  [AXES];
    logic [AW-1:0]         arm_abs;

    always_comb begin
        arm_abs = dv_prep.arm[AW-1] ? (~dv_prep.arm + AW'(1)) : dv_prep.arm;
        for (int i = 0; i < AXES; i++) begin
            if (dv_prep.zero) begin
                nmag[i] = (i == 0) ? NORM_ONE : '0;
                nneg[i] = 1'b0;
            end else begin
                nmag[i] = dv_quo[i];
                nneg[i] = dv_prep.dneg[i];
            end
            nval[i] = NORM_WIDTH'(nmag[i]);
            if (nneg[i]) begin
                nval[i] = ~nval[i] + NORM_WIDTH'(1);
            end
        end
    end

    logic                   st5_valid_reg;
    logic [PRW-1:0]         st5_prod_reg [AXES];
    logic                   st5_pneg_reg [AXES];
    logic [NORM_WIDTH-1:0]  st5_norm_reg [AXES];
    logic [AXES-1:0][CW-1:0] st5_a_reg;
    logic [ID_WIDTH-1:0]    st5_ida_reg, st5_idb_reg;
    logic [CW-1:0]          st5_pen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st5_valid_reg <= 1'b0;
        end else if (adv) begin
            st5_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st5_a_reg   <= dv_prep.a;
            st5_ida_reg <= dv_prep.ida;
            st5_idb_reg <= dv_prep.idb;
            st5_pen_reg <= dv_prep.pen;
            for (int i = 0; i < AXES; i++) begin
                st5_prod_reg[i] <= PRW'(nmag[i]) * PRW'(arm_abs[CW:0]);
                st5_pneg_reg[i] <= nneg[i] ^ dv_prep.arm[AW-1];
                st5_norm_reg[i] <= nval[i];
            end
        end
    end

    // stage 6: round offset, move the point, saturate
    logic [PRW:0]           rnd   [AXES];
    logic [OFW-1:0]         off   [AXES];
    logic [PW-1:0]          pwide [AXES];
    logic [AXES-1:0][CW-1:0] pnt;
    logic [PXW-1:0]         pen_x;
    logic [PEN_WIDTH-1:0]   pen_out;
    ssc_res_t               res_next;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            rnd[i] = {1'b0, st5_prod_reg[i]} + (PRW+1)'(1 << NORM_FRAC);
            off[i] = rnd[i][PRW:NORM_FRAC+1];
            if (st5_pneg_reg[i]) begin
                pwide[i] = {{3{st5_a_reg[i][CW-1]}}, st5_a_reg[i]} - PW'(off[i]);
            end else begin
                pwide[i] = {{3{st5_a_reg[i][CW-1]}}, st5_a_reg[i]} + PW'(off[i]);
            end
            if (pwide[i][PW-1] && !(&pwide[i][PW-1:CW-1])) begin
                pnt[i] = {1'b1, {(CW-1){1'b0}}};
            end else if (!pwide[i][PW-1] && (|pwide[i][PW-2:CW-1])) begin
                pnt[i] = {1'b0, {(CW-1){1'b1}}};
            end else begin
                pnt[i] = pwide[i][CW-1:0];
            end
        end
        pen_x   = PXW'(st5_pen_reg);
        pen_out = (pen_x > PXW'({PEN_WIDTH{1'b1}})) ? {PEN_WIDTH{1'b1}}
                                                    : pen_x[PEN_WIDTH-1:0];
        res_next.body_a            = st5_ida_reg;
        res_next.body_b            = st5_idb_reg;
        res_next.point_x           = pnt[0];
        res_next.point_y           = pnt[1];
        res_next.point_z           = pnt[2];
        res_next.normal_x          = st5_norm_reg[0];
        res_next.normal_y          = st5_norm_reg[1];
        res_next.normal_z          = st5_norm_reg[2];
        res_next.penetration_depth = pen_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= st5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `SSC_ASSERT_IMPL(a_ready_tracks_out, 1'b1, s_ready == (!m_valid || m_ready))
    `SSC_ASSERT_IMPL(a_normal_range, m_valid, (m_data.normal_x <= 16'sd16384) && (m_data.normal_x >= -16'sd16384))
    `SSC_ASSERT_IMPL(a_pen_nonzero, m_valid, m_data.penetration_depth != '0)
    `SSC_ASSERT_NEXT(a_out_from_last, m_valid && m_ready, m_valid == $past(st5_valid_reg))

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import ssc_pkg::*;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ssc_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    ssc_res_t m_data;

    sphere_sphere_contact DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    localparam int LATENCY     = COORD_WIDTH + 21;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    ssc_res_t    contact_queue[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          sink_wait   = 0;
    logic        hold_active = 1'b0;
    logic        sink_idle   = 1'b0;
    event        hold_go;

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // exact integer square root, rounded down
    function automatic logic [63:0] isqrt(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= v) begin
                r = c;
            end
        end
        return r;
    endfunction

    // contact prediction for one pair; returns 0 when the spheres do not overlap
    function automatic bit predict_contact(ssc_req_t rq, output ssc_res_t ct);
        logic signed [63:0]  ctr[3];
        logic signed [63:0]  dlt[3];
        logic signed [63:0]  nrm[3];
        logic [63:0]         dmag;
        logic [127:0]        dist2;
        logic [127:0]        rsum2;
        logic [63:0]         rsum;
        logic [63:0]         cdist;
        logic [63:0]         pen;
        logic [63:0]         q;
        logic signed [63:0]  s2;
        logic [63:0]         m;
        logic [63:0]         off;
        logic signed [63:0]  p;
        logic signed [63:0]  lim_hi;
        logic signed [63:0]  lim_lo;
        lim_hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
        lim_lo = -lim_hi - 1;
        ctr[0] = rq.first_center_x;
        ctr[1] = rq.first_center_y;
        ctr[2] = rq.first_center_z;
        dlt[0] = 64'(rq.second_center_x) - ctr[0];
        dlt[1] = 64'(rq.second_center_y) - ctr[1];
        dlt[2] = 64'(rq.second_center_z) - ctr[2];
        dist2 = '0;
        for (int i = 0; i < 3; i++) begin
            dmag  = dlt[i] < 0 ? -dlt[i] : dlt[i];
            dist2 = dist2 + {64'd0, dmag} * {64'd0, dmag};
        end
        rsum  = 64'(rq.first_radius) + 64'(rq.second_radius);
        rsum2 = {64'd0, rsum} * {64'd0, rsum};
        if (dist2 >= rsum2) begin
            return 1'b0;
        end
        cdist = isqrt(dist2);
        if (cdist == 0) begin
            nrm[0] = NORM_ONE;
            nrm[1] = 0;
            nrm[2] = 0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                dmag   = dlt[i] < 0 ? -dlt[i] : dlt[i];
                q      = ((dmag << 14) + (cdist >> 1)) / cdist;
                nrm[i] = dlt[i] < 0 ? -$signed(q) : $signed(q);
            end
        end
        pen = rsum - cdist;
        s2  = $signed(2 * 64'(rq.first_radius)) - $signed(pen);
        for (int i = 0; i < 3; i++) begin
            m   = (nrm[i] < 0 ? -nrm[i] : nrm[i]) * (s2 < 0 ? -s2 : s2);
            off = (m + (64'd1 << 14)) >> 15;
            p   = ((nrm[i] < 0) != (s2 < 0)) ? ctr[i] - $signed(off)
                                             : ctr[i] + $signed(off);
            if (p > lim_hi) p = lim_hi;
            if (p < lim_lo) p = lim_lo;
            nrm[i] = nrm[i];
            case (i)
                0: ct.point_x = p[COORD_WIDTH-1:0];
                1: ct.point_y = p[COORD_WIDTH-1:0];
                default: ct.point_z = p[COORD_WIDTH-1:0];
            endcase
        end
        ct.body_a            = rq.first_id;
        ct.body_b            = rq.second_id;
        ct.normal_x          = nrm[0][NORM_WIDTH-1:0];
        ct.normal_y          = nrm[1][NORM_WIDTH-1:0];
        ct.normal_z          = nrm[2][NORM_WIDTH-1:0];
        ct.penetration_depth = pen > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : pen[31:0];
        return 1'b1;
    endfunction

    // offer one request after a random gap, then wait for acceptance;
    // valid stays up after acceptance unless a gap follows
    task automatic send_pair(ssc_req_t rq, bit no_gap = 0);
        ssc_res_t ct;
        int       gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (predict_contact(rq, ct)) contact_queue = {contact_queue, ct};
    endtask

    // long receiver hold-off, counted in cycles
    always begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
    end

    // receiver: after each accepted contact, may hold ready low for a random wait, none when idle
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait <= 0;
        end else begin
            w = sink_wait;
            if (m_valid && m_ready) begin
                w = sink_idle ? 0 : int'($urandom_range(0, 7));
            end else if (w > 0) begin
                w = w - 1;
            end
            sink_wait <= w;
            m_ready   <= !hold_active && (w == 0);
        end
    end

    // contact checker
    always @(posedge aclk) begin
        ssc_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (contact_queue.size() == 0) begin
                $display("%0t: unexpected contact %h", $time, m_data);
                error_count++;
            end else begin
                want = contact_queue.pop_front();
                if (m_data.body_a !== want.body_a)
                    $display("%0t: body_a exp %h got %h", $time, want.body_a, m_data.body_a);
                if (m_data.body_b !== want.body_b)
                    $display("%0t: body_b exp %h got %h", $time, want.body_b, m_data.body_b);
                if (m_data.point_x !== want.point_x)
                    $display("%0t: point_x exp %h got %h", $time, want.point_x, m_data.point_x);
                if (m_data.point_y !== want.point_y)
                    $display("%0t: point_y exp %h got %h", $time, want.point_y, m_data.point_y);
                if (m_data.point_z !== want.point_z)
                    $display("%0t: point_z exp %h got %h", $time, want.point_z, m_data.point_z);
                if (m_data.normal_x !== want.normal_x)
                    $display("%0t: normal_x exp %h got %h", $time, want.normal_x,
                             m_data.normal_x);
                if (m_data.normal_y !== want.normal_y)
                    $display("%0t: normal_y exp %h got %h", $time, want.normal_y,
                             m_data.normal_y);
                if (m_data.normal_z !== want.normal_z)
                    $display("%0t: normal_z exp %h got %h", $time, want.normal_z,
                             m_data.normal_z);
                if (m_data.penetration_depth !== want.penetration_depth)
                    $display("%0t: penetration exp %h got %h", $time,
                             want.penetration_depth, m_data.penetration_depth);
                if (m_data !== want) error_count++;
            end
        end
    end

    function automatic ssc_req_t make_pair(logic signed [31:0] ax, logic signed [31:0] ay,
                                           logic signed [31:0] az, logic [30:0] ar,
                                           logic signed [31:0] bx, logic signed [31:0] by,
                                           logic signed [31:0] bz, logic [30:0] br);
        ssc_req_t rq;
        rq.first_id        = 16'($urandom);
        rq.second_id       = 16'($urandom);
        rq.first_center_x  = ax;
        rq.first_center_y  = ay;
        rq.first_center_z  = az;
        rq.first_radius    = ar;
        rq.second_center_x = bx;
        rq.second_center_y = by;
        rq.second_center_z = bz;
        rq.second_radius   = br;
        return rq;
    endfunction

    // offset of up to 2^sh per axis, so most pairs sit near each other
    function automatic logic signed [31:0] near(logic signed [31:0] c, int sh);
        logic signed [63:0] v;
        v = 64'(c) + $signed(64'($urandom)) % (64'sd1 <<< sh);
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) v = -64'sh8000_0000;
        return v[31:0];
    endfunction

    // extremes, coincident centres, touching and zero radii
    task automatic test_directed();
        localparam logic [30:0] RMAX = 31'h7FFF_FFFF;
        localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] CMIN = -32'sh8000_0000;
        ssc_req_t rq;
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 31'h10000, 0, 0, 0, 31'h10000));
        send_pair(make_pair(5, -7, 9, 1, 5, -7, 9, 0));
        send_pair(make_pair(0, 0, 0, 31'h10000, 32'h20000, 0, 0, 31'h10000));
        send_pair(make_pair(0, 0, 0, 31'h10000, 32'h1FFFF, 0, 0, 31'h10000));
        send_pair(make_pair(0, 0, 0, 31'h10000, 0, -32'h8000, 0, 31'h10000));
        send_pair(make_pair(0, 0, 0, 31'h10000, 0, 0, 32'h8000, 31'h10000));
        send_pair(make_pair(CMAX, CMAX, CMAX, RMAX, CMIN, CMIN, CMIN, RMAX));
        send_pair(make_pair(CMIN, CMIN, CMIN, RMAX, CMAX, CMAX, CMAX, RMAX));
        send_pair(make_pair(CMAX, CMAX, CMAX, RMAX, CMAX, CMAX, CMAX, RMAX));
        send_pair(make_pair(CMIN, CMIN, CMIN, 0, CMIN, CMIN, CMIN, RMAX));
        send_pair(make_pair(CMAX, 0, CMIN, RMAX, CMAX - 1, 1, CMIN + 1, 0));
        send_pair(make_pair(CMIN, 0, 0, 0, CMAX, 0, 0, RMAX));
        send_pair(make_pair(0, 0, 0, 3, 1, 1, 1, 0));
        send_pair(make_pair(100, 200, 300, 31'h30000, -400, 500, -600, 31'h2000));
        rq = make_pair(0, 0, 0, RMAX, 0, 0, 0, RMAX);
        rq.first_id  = 16'hFFFF;
        rq.second_id = 16'h0000;
        send_pair(rq);
        rq.first_id  = 16'h0000;
        rq.second_id = 16'hFFFF;
        send_pair(rq);
    endtask

    // random pairs: mostly near neighbors of mixed scale, some wide noise
    task automatic test_random(int count);
        ssc_req_t rq;
        int       sh;
        for (int k = 0; k < count; k++) begin
            rq = ssc_req_t'($bits(ssc_req_t)'({$urandom, $urandom, $urandom, $urandom,
                                               $urandom, $urandom, $urandom, $urandom,
                                               $urandom, $urandom}));
            if ($urandom_range(0, 9) != 0) begin
                sh = $urandom_range(4, 30);
                rq.second_center_x = near(rq.first_center_x, sh);
                rq.second_center_y = near(rq.first_center_y, sh);
                rq.second_center_z = near(rq.first_center_z, sh);
                rq.first_radius    = 31'($urandom_range(0, 3)) << $urandom_range(0, sh);
                rq.second_radius   = 31'($urandom) >> (30 - sh + $urandom_range(0, 2));
                if ($urandom_range(0, 15) == 0) rq.second_center_x = rq.first_center_x;
            end
            send_pair(rq);
        end
    endtask

    // receiver holds off while requests keep coming, so the pipeline backs up
    task automatic test_backpressure();
        ssc_req_t rq;
        -> hold_go;
        for (int k = 0; k < 150; k++) begin
            rq = make_pair(32'($urandom_range(0, 255)), 0, 0, 31'h100,
                           32'($urandom_range(0, 255)), 0, 0, 31'h100);
            send_pair(rq, 1);
        end
    endtask

    // no random stalls on either side
    task automatic test_streaming();
        sink_idle = 1'b1;
        for (int k = 0; k < 100; k++) begin
            send_pair(make_pair(32'($urandom), 0, 32'($urandom_range(0, 65535)),
                                31'h40000, 32'($urandom), 32'($urandom_range(0, 65535)),
                                0, 31'($urandom)), 1);
        end
        sink_idle = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(700);
        test_backpressure();
        test_streaming();
        test_random(800);
        s_valid <= 1'b0;
        while (contact_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
